// ===== sv/tfn_pkg.sv =====
package tfn_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int OUT_BITS       = 16;

  // Control that travels with each item down the pipe
  typedef struct packed {
    logic       valid;
    logic [2:0] neg;     // sign of each cross product component
    logic       degen;   // cross product is the zero vector
  } tfn_ctl_t;

endpackage

// ===== sv/tfn_front.sv =====
module tfn_front import tfn_pkg::*; #(
  parameter int COORD_BITS       = COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] ax,
  input  logic [COORD_BITS-1:0] ay,
  input  logic [COORD_BITS-1:0] az,
  input  logic [COORD_BITS-1:0] bx,
  input  logic [COORD_BITS-1:0] by_coord,
  input  logic [COORD_BITS-1:0] bz,
  input  logic [COORD_BITS-1:0] cx,
  input  logic [COORD_BITS-1:0] cy,
  input  logic [COORD_BITS-1:0] cz,
  input  logic                  dn_load,
  output tfn_ctl_t              ctl_o,
  output logic signed [2*(2*(COORD_BITS+1))+2*NORMAL_FRAC_BITS+7:0] s_o,
  output logic signed [2*(2*(COORD_BITS+1))+2*NORMAL_FRAC_BITS+7:0] r_o [3],
  output logic signed [2*(2*(COORD_BITS+1))+2*NORMAL_FRAC_BITS+7:0] p_o [3]
);

  localparam int DW = COORD_BITS + 1;       // edge vector width
  localparam int CW = 2 * DW + 1;           // cross product width
  localparam int MW = 2 * DW;               // magnitude width
  localparam int SW = 2 * MW + 2;           // sum of squares width
  localparam int W  = 2 * MW + 2 * NORMAL_FRAC_BITS + 8;
  localparam int NS = 7;

  logic [NS-1:0] v_r;
  logic [NS-1:0] ld;

  logic signed [DW-1:0]   uu_r [3];
  logic signed [DW-1:0]   vv_r [3];
  logic signed [2*DW-1:0] prod_r [6];
  logic [MW-1:0]          mag_r [3];
  logic [2*DW-1:0]        hh_r [3];
  logic [2*DW-1:0]        hl_r [3];
  logic [2*DW-1:0]        ll_r [3];
  logic [2*MW-1:0]        m2_r [3];
  logic [2*MW-1:0]        m2b_r [3];
  logic [SW-1:0]          s5_r;
  logic signed [W-1:0]    s6_r;
  logic signed [W-1:0]    r6_r [3];
  logic signed [W-1:0]    p6_r [3];
  logic [3:0]             fl_r [2:NS-1];

  logic signed [CW-1:0]   cp [3];
  logic signed [CW-1:0]   cabs [3];

  // Stall chain: a stage loads when it is empty or its successor loads
  always_comb begin
    ld[NS-1] = !v_r[NS-1] | dn_load;
    for (int i = NS - 2; i >= 0; i--) begin
      ld[i] = !v_r[i] | ld[i+1];
    end
  end

  assign in_ready = ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (ld[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_comb begin
    cp[0] = CW'(prod_r[0]) - CW'(prod_r[1]);
    cp[1] = CW'(prod_r[2]) - CW'(prod_r[3]);
    cp[2] = CW'(prod_r[4]) - CW'(prod_r[5]);
    for (int i = 0; i < 3; i++) begin
      cabs[i] = cp[i][CW-1] ? -cp[i] : cp[i];
    end
  end

  always_ff @(posedge clk) begin
    // u = B - C, v = B - A
    if (ld[0]) begin
      uu_r[0] <= $signed({bx[COORD_BITS-1], bx}) - $signed({cx[COORD_BITS-1], cx});
      uu_r[1] <= $signed({by_coord[COORD_BITS-1], by_coord})
               - $signed({cy[COORD_BITS-1], cy});
      uu_r[2] <= $signed({bz[COORD_BITS-1], bz}) - $signed({cz[COORD_BITS-1], cz});
      vv_r[0] <= $signed({bx[COORD_BITS-1], bx}) - $signed({ax[COORD_BITS-1], ax});
      vv_r[1] <= $signed({by_coord[COORD_BITS-1], by_coord})
               - $signed({ay[COORD_BITS-1], ay});
      vv_r[2] <= $signed({bz[COORD_BITS-1], bz}) - $signed({az[COORD_BITS-1], az});
    end
    if (ld[1]) begin
      prod_r[0] <= uu_r[1] * vv_r[2];
      prod_r[1] <= uu_r[2] * vv_r[1];
      prod_r[2] <= uu_r[2] * vv_r[0];
      prod_r[3] <= uu_r[0] * vv_r[2];
      prod_r[4] <= uu_r[0] * vv_r[1];
      prod_r[5] <= uu_r[1] * vv_r[0];
    end
    if (ld[2]) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= MW'(cabs[i]);
      end
      fl_r[2] <= {cp[0][CW-1], cp[1][CW-1], cp[2][CW-1],
                  (cp[0] == '0) && (cp[1] == '0) && (cp[2] == '0)};
    end
    // square of each magnitude from three half-width products
    if (ld[3]) begin
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= mag_r[i][MW-1:DW] * mag_r[i][MW-1:DW];
        hl_r[i] <= mag_r[i][MW-1:DW] * mag_r[i][DW-1:0];
        ll_r[i] <= mag_r[i][DW-1:0] * mag_r[i][DW-1:0];
      end
      fl_r[3] <= fl_r[2];
    end
    if (ld[4]) begin
      for (int i = 0; i < 3; i++) begin
        m2_r[i] <= ((2*MW)'(hh_r[i]) << (2*DW)) + ((2*MW)'(hl_r[i]) << (DW+1))
                 + (2*MW)'(ll_r[i]);
      end
      fl_r[4] <= fl_r[3];
    end
    if (ld[5]) begin
      s5_r  <= SW'(m2_r[0]) + SW'(m2_r[1]) + SW'(m2_r[2]);
      m2b_r <= m2_r;
      fl_r[5] <= fl_r[4];
    end
    // seed for k = 0: R = 4 m^2 2^(2F) - s, P = (2k-1) s = -s
    if (ld[6]) begin
      s6_r <= $signed(W'(s5_r));
      for (int i = 0; i < 3; i++) begin
        r6_r[i] <= $signed(W'(m2b_r[i]) << (2*NORMAL_FRAC_BITS + 2)) - $signed(W'(s5_r));
        p6_r[i] <= -$signed(W'(s5_r));
      end
      fl_r[6] <= fl_r[5];
    end
  end

  assign ctl_o = '{valid: v_r[NS-1], neg: fl_r[NS-1][3:1], degen: fl_r[NS-1][0]};
  assign s_o   = s6_r;
  assign r_o   = r6_r;
  assign p_o   = p6_r;

endmodule

// ===== sv/tfn_cell.sv =====
module tfn_cell import tfn_pkg::*; #(
  parameter int COORD_BITS       = COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = FRAC_BITS_DEF,
  parameter int J                = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      ld,
  input  tfn_ctl_t                  ctl_i,
  input  logic [NORMAL_FRAC_BITS:0] k_i [3],
  input  logic signed [2*(2*(COORD_BITS+1))+2*NORMAL_FRAC_BITS+7:0] s_i,
  input  logic signed [2*(2*(COORD_BITS+1))+2*NORMAL_FRAC_BITS+7:0] r_i [3],
  input  logic signed [2*(2*(COORD_BITS+1))+2*NORMAL_FRAC_BITS+7:0] p_i [3],
  output tfn_ctl_t                  ctl_o,
  output logic [NORMAL_FRAC_BITS:0] k_o [3],
  output logic signed [2*(2*(COORD_BITS+1))+2*NORMAL_FRAC_BITS+7:0] s_o,
  output logic signed [2*(2*(COORD_BITS+1))+2*NORMAL_FRAC_BITS+7:0] r_o [3],
  output logic signed [2*(2*(COORD_BITS+1))+2*NORMAL_FRAC_BITS+7:0] p_o [3]
);

  localparam int W = 2 * (2 * (COORD_BITS + 1)) + 2 * NORMAL_FRAC_BITS + 8;

  tfn_ctl_t                  ctl_r;
  logic [NORMAL_FRAC_BITS:0] k_r [3];
  logic [NORMAL_FRAC_BITS:0] k_nxt [3];
  logic signed [W-1:0]       s_r;
  logic signed [W-1:0]       r_r [3];
  logic signed [W-1:0]       r_nxt [3];
  logic signed [W-1:0]       p_r [3];
  logic signed [W-1:0]       p_nxt [3];
  logic signed [W-1:0]       d [3];

  // Trial bit J: (2k'-1)^2 s = (2k-1)^2 s + 2^(J+2) P + 2^(2J+2) s
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i] = r_i[i] - (p_i[i] <<< (J + 2)) - (s_i <<< (2*J + 2));
      if (!d[i][W-1]) begin
        r_nxt[i] = d[i];
        p_nxt[i] = p_i[i] + (s_i <<< (J + 1));
        k_nxt[i] = k_i[i] | ((NORMAL_FRAC_BITS+1)'(1) << J);
      end else begin
        r_nxt[i] = r_i[i];
        p_nxt[i] = p_i[i];
        k_nxt[i] = k_i[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (ld) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      s_r <= s_i;
      r_r <= r_nxt;
      p_r <= p_nxt;
      k_r <= k_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign k_o   = k_r;
  assign s_o   = s_r;
  assign r_o   = r_r;
  assign p_o   = p_r;

endmodule

// ===== sv/triangle_face_normal.sv =====
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-------------------------------------
// in_      | input     | in_valid / in_ready  | in_ax .. in_cz, corners A, B, C
// out_     | output    | out_valid / out_ready| out_nx/ny/nz (Q1.14), out_degenerate
//
// One item per clock sustained while out_ready stays high. Pipe:
// 7 front stages (edges, products, cross, squares, sum, seed), one cell per
// result bit, one output register.
// Each cell settles one bit of the rounded magnitude for all three components.
// rst_n is synchronous and clears only the valid bits and the cells' control fields.
// A stall at the output fills bubbles first; in_ready drops only when every stage is full.
module triangle_face_normal import tfn_pkg::*; #(
  parameter int COORD_BITS       = COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_ax,
  input  logic [COORD_BITS-1:0] in_ay,
  input  logic [COORD_BITS-1:0] in_az,
  input  logic [COORD_BITS-1:0] in_bx,
  input  logic [COORD_BITS-1:0] in_by_coord,
  input  logic [COORD_BITS-1:0] in_bz,
  input  logic [COORD_BITS-1:0] in_cx,
  input  logic [COORD_BITS-1:0] in_cy,
  input  logic [COORD_BITS-1:0] in_cz,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_BITS-1:0]   out_nx,
  output logic [OUT_BITS-1:0]   out_ny,
  output logic [OUT_BITS-1:0]   out_nz,
  output logic                  out_degenerate
);

  localparam int W  = 2 * (2 * (COORD_BITS + 1)) + 2 * NORMAL_FRAC_BITS + 8;
  localparam int NC = NORMAL_FRAC_BITS + 1;   // cells, one per magnitude bit
  localparam int KW = NORMAL_FRAC_BITS + 1;

  // Links between cells: index 0 is the front, index p+1 is cell p
  tfn_ctl_t            ctl_w [NC+1];
  logic [KW-1:0]       k_w   [NC+1][3];
  logic signed [W-1:0] s_w   [NC+1];
  logic signed [W-1:0] r_w   [NC+1][3];
  logic signed [W-1:0] p_w   [NC+1][3];
  logic [NC-1:0]       ld_c;
  logic                ld_o;

  logic                out_valid_r;
  logic [OUT_BITS-1:0] n_r [3];
  logic                degen_r;
  logic signed [KW:0]  sv [3];

  tfn_front #(
    .COORD_BITS       (COORD_BITS),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ax       (in_ax),
    .ay       (in_ay),
    .az       (in_az),
    .bx       (in_bx),
    .by_coord (in_by_coord),
    .bz       (in_bz),
    .cx       (in_cx),
    .cy       (in_cy),
    .cz       (in_cz),
    .dn_load  (ld_c[0]),
    .ctl_o    (ctl_w[0]),
    .s_o      (s_w[0]),
    .r_o      (r_w[0]),
    .p_o      (p_w[0])
  );

  // magnitude starts at zero
  assign k_w[0] = '{default: '0};

  // Most significant bit first: cell p settles bit NORMAL_FRAC_BITS - p
  for (genvar p = 0; p < NC; p++) begin : g_cell
    tfn_cell #(
      .COORD_BITS       (COORD_BITS),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
      .J                (NORMAL_FRAC_BITS - p)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ld    (ld_c[p]),
      .ctl_i (ctl_w[p]),
      .k_i   (k_w[p]),
      .s_i   (s_w[p]),
      .r_i   (r_w[p]),
      .p_i   (p_w[p]),
      .ctl_o (ctl_w[p+1]),
      .k_o   (k_w[p+1]),
      .s_o   (s_w[p+1]),
      .r_o   (r_w[p+1]),
      .p_o   (p_w[p+1])
    );
  end

  // A stage loads when empty or when the stage after it loads
  assign ld_o = !out_valid_r | out_ready;

  always_comb begin
    ld_c[NC-1] = !ctl_w[NC].valid | ld_o;
    for (int p = NC - 2; p >= 0; p--) begin
      ld_c[p] = !ctl_w[p+1].valid | ld_c[p+1];
    end
  end

  // Apply sign; a zero cross product gives the zero vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sv[i] = ctl_w[NC].neg[2-i] ? -$signed({1'b0, k_w[NC][i]})
                                 :  $signed({1'b0, k_w[NC][i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_o) begin
      out_valid_r <= ctl_w[NC].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_o) begin
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= ctl_w[NC].degen ? '0 : OUT_BITS'(sv[i]);
      end
      degen_r <= ctl_w[NC].degen;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_nx         = n_r[0];
  assign out_ny         = n_r[1];
  assign out_nz         = n_r[2];
  assign out_degenerate = degen_r;

endmodule

// ===== sv/tfn_checker.sv =====
module tfn_checker import tfn_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [OUT_BITS-1:0] out_nx,
  input logic [OUT_BITS-1:0] out_ny,
  input logic [OUT_BITS-1:0] out_nz,
  input logic                out_degenerate
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_nx) && $stable(out_ny)
                                && $stable(out_nz) && $stable(out_degenerate))
    else $error("stalled result changed");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_nx == '0 && out_ny == '0 && out_nz == '0)
    else $error("degenerate item with nonzero normal");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (.*);
